/* rtl/core/bbss_pkg.sv */
// Package: constants, types and helpers shared by the seed selector modules.
package bbss_pkg;

	localparam int BoxGrid = 15;
	localparam int NumBox = BoxGrid * BoxGrid;
	localparam int BoxW = $clog2(NumBox);
	localparam int BinW = $clog2(BoxGrid);
	localparam int SlopeW = 24;
	localparam int PosW = 16;
	localparam int HeightW = 20;
	localparam int QuotaW = 11;
	localparam int EntryW = SlopeW + 2 * PosW + HeightW;
	localparam int ProdW = PosW + BinW + 1;
	localparam int CfgIdxW = 2;

	localparam logic [1:0] ACT_LOAD  = 2'd0;
	localparam logic [1:0] ACT_FETCH = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;

	localparam logic [CfgIdxW-1:0] REG_DESC    = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_SAMPLES = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_LINES   = 2'd2;
	localparam logic [CfgIdxW-1:0] REG_QUOTA   = 2'd3;

	typedef struct packed {
		logic [SlopeW-1:0]         slope;
		logic [PosW-1:0]           y;
		logic [PosW-1:0]           x;
		logic signed [HeightW-1:0] height;
	} entry_t;

	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} div_ctl_t;

endpackage

/* rtl/core/bbss_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module bbss_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

/* rtl/core/bbss_bin.sv */
// Restoring divider that turns a position into a clamped box column or row.
module bbss_bin (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [bbss_pkg::PosW-1:0]     pos,
	input  logic [bbss_pkg::PosW-1:0]     extent,
	output logic                          done,
	output logic [bbss_pkg::BinW-1:0]     bin
);
	import bbss_pkg::*;

	localparam int CntW = $clog2(ProdW + 1);

	logic [ProdW-1:0] quo_q;
	logic [PosW:0]    rem_q;
	logic [PosW-1:0]  div_q;
	logic [CntW-1:0]  cnt_q;
	logic             run_q;
	logic [PosW:0]    trial;
	logic [PosW:0]    sub;

	assign trial = {rem_q[PosW-1:0], quo_q[ProdW-1]};
	assign sub   = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CntW'(ProdW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	// one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= ProdW'(pos) * ProdW'(BoxGrid);
			rem_q <= '0;
			div_q <= (extent == '0) ? PosW'(1) : extent;
		end else if (run_q) begin
			if (!sub[PosW]) begin
				rem_q <= sub;
				quo_q <= {quo_q[ProdW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[ProdW-2:0], 1'b0};
			end
		end
	end

	assign bin = (quo_q > ProdW'(BoxGrid - 1)) ? BinW'(BoxGrid - 1) : quo_q[BinW-1:0];
endmodule

/* rtl/core/binned_best_seed_selector.sv */
// Top level of the binned best-seed selector: control, box flags and entry RAM.
//
//  channel | dir | handshake            | payload
//  s_axis  | in  | s_axis_tvalid/tready | tuser action, tdata x,y,height,slope
//  m_axis  | out | m_axis_tvalid/tready | tdata found,x,y,height
//  cfg     | in  | cfg_we               | cfg_index, cfg_data
//
// A load with a nonzero positive height gets the two box indexes from two
// bit-serial dividers (21 steps each, in parallel), then one RAM read and write-back.
// A fetch under quota scans all 225 boxes through the entry RAM, one read a cycle.
// A clear resets the fetch count and the flags, which are flip-flops cleared at once.
// Reset clears control and flags, the RAM needs none. Input is held off while
// a word works or a result waits on m_axis_tready.
module binned_best_seed_selector (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// tdata: pos_x[15:0], pos_y[31:16], height[51:32], slope_error[75:52], zero pad
	input  logic [79:0] s_axis_tdata,
	// tuser: action[1:0]
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// tdata: found[0], out_x[16:1], out_y[32:17], out_height[52:33], zero pad
	output logic [55:0] m_axis_tdata,
	input  logic        cfg_we,
	input  logic [bbss_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [15:0] cfg_data
);
	import bbss_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DIV   = 3'd1;
	localparam logic [2:0] ST_LREAD = 3'd2;
	localparam logic [2:0] ST_LUPD  = 3'd3;
	localparam logic [2:0] ST_SCAN  = 3'd4;
	localparam logic [2:0] ST_SLAST = 3'd5;
	localparam logic [2:0] ST_FRD   = 3'd6;
	localparam logic [2:0] ST_OUT   = 3'd7;

	logic              desc_q;
	logic [PosW-1:0]   samples_q, lines_q;
	logic [QuotaW-1:0] quota_q, count_q;
	logic [NumBox-1:0] occ_q, ret_q;
	logic [2:0]        state_q;
	entry_t            in_q;
	logic [BoxW-1:0]   box_q, scan_q, best_q;
	logic              have_q, rd_valid_s1, colx_done_q, rowy_done_q;
	logic [BoxW-1:0]   rd_idx_s1;
	logic [SlopeW-1:0] best_slope_q;
	logic              found_q;

	div_ctl_t          dctl;
	logic              dx_done, dy_done;
	logic [BinW-1:0]   col, row;

	logic              we;
	logic [BoxW-1:0]   raddr;
	entry_t            rdata;
	logic              accept;
	logic              take;

	assign accept        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = (state_q == ST_OUT);
	// hold the read address on the picked box so its word stays on rdata
	assign m_axis_tdata  = found_q ? {3'b0, rdata.height, rdata.y, rdata.x, 1'b1} : '0;
	assign dctl.start    = accept && (s_axis_tuser == ACT_LOAD) &&
	                       !s_axis_tdata[51] && (s_axis_tdata[51:32] != '0);
	assign dctl.busy     = (state_q == ST_DIV);
	assign dctl.done     = (colx_done_q || dx_done) && (rowy_done_q || dy_done);

	bbss_bin u_binx (.clk, .arst_n, .start(dctl.start), .pos(s_axis_tdata[15:0]),
		.extent(samples_q), .done(dx_done), .bin(col));
	bbss_bin u_biny (.clk, .arst_n, .start(dctl.start), .pos(s_axis_tdata[31:16]),
		.extent(lines_q), .done(dy_done), .bin(row));

	bbss_ram #(.Width(EntryW), .Depth(NumBox)) u_ram (.clk, .we, .waddr(box_q),
		.wdata(in_q), .raddr, .rdata);

	assign raddr = (state_q == ST_FRD || state_q == ST_OUT) ? best_q :
	               (state_q == ST_SCAN) ? scan_q : box_q;
	assign we    = (state_q == ST_LUPD) && !ret_q[box_q] && (!occ_q[box_q] ||
	               (desc_q ? (in_q.slope > rdata.slope) : (in_q.slope < rdata.slope)));

	// compare the registered RAM word of the scanned box against the running best
	assign take  = rd_valid_s1 && occ_q[rd_idx_s1] && !ret_q[rd_idx_s1] && (!have_q ||
	               (desc_q ? (rdata.slope > best_slope_q) : (rdata.slope < best_slope_q)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			desc_q    <= 1'b0;
			samples_q <= 16'd1024;
			lines_q   <= 16'd1024;
			quota_q   <= 11'd157;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DESC:    desc_q    <= cfg_data[0];
				REG_SAMPLES: samples_q <= cfg_data;
				REG_LINES:   lines_q   <= cfg_data;
				REG_QUOTA:   quota_q   <= cfg_data[QuotaW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			occ_q       <= '0;
			ret_q       <= '0;
			count_q     <= '0;
			have_q      <= 1'b0;
			rd_valid_s1 <= 1'b0;
			colx_done_q <= 1'b0;
			rowy_done_q <= 1'b0;
			scan_q      <= '0;
			found_q     <= 1'b0;
		end else begin
			rd_valid_s1 <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (s_axis_tuser)
							ACT_LOAD: if (dctl.start) state_q <= ST_DIV;
							ACT_FETCH: begin
								have_q  <= 1'b0;
								found_q <= 1'b0;
								scan_q  <= '0;
								if (count_q >= quota_q) state_q <= ST_OUT;
								else state_q <= ST_SCAN;
							end
							ACT_CLEAR: begin
								occ_q   <= '0;
								ret_q   <= '0;
								count_q <= '0;
							end
							default: ;
						endcase
					end
				end
				ST_DIV: begin
					if (dx_done) colx_done_q <= 1'b1;
					if (dy_done) rowy_done_q <= 1'b1;
					if (dctl.busy && dctl.done) begin
						colx_done_q <= 1'b0;
						rowy_done_q <= 1'b0;
						state_q     <= ST_LREAD;
					end
				end
				ST_LREAD: state_q <= ST_LUPD;
				ST_LUPD: begin
					if (we) occ_q[box_q] <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_SCAN: begin
					rd_valid_s1 <= 1'b1;
					if (scan_q == BoxW'(NumBox - 1)) state_q <= ST_SLAST;
					else scan_q <= scan_q + 1'b1;
				end
				// the last box is still being compared here
				ST_SLAST: state_q <= (have_q || take) ? ST_FRD : ST_OUT;
				ST_FRD: begin
					state_q <= ST_OUT;
					ret_q[best_q] <= 1'b1;
					count_q <= count_q + 1'b1;
					found_q <= 1'b1;
				end
				ST_OUT: if (m_axis_tready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
			if (take) have_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= scan_q;
		if (accept) in_q <= {s_axis_tdata[75:52], s_axis_tdata[31:16],
		                     s_axis_tdata[15:0], s_axis_tdata[51:32]};
		if (dctl.busy && dctl.done)
			box_q <= BoxW'({1'b0, row} * BoxGrid + {1'b0, col});
		if (take) begin
			best_q       <= rd_idx_s1;
			best_slope_q <= rdata.slope;
		end
	end
endmodule
